// ===== rtl/channel_demux_table_top_macros.svh =====
// Assertion shorthands used by the checker of this block
`ifndef CHANNEL_DEMUX_TABLE_TOP_MACROS_SVH
`define CHANNEL_DEMUX_TABLE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high
`define CHDT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("channel demux check failed");

// Next-cycle implication, off while reset is high
`define CHDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("channel demux check failed");

`endif

// ===== rtl/chdt_pkg.sv =====
package chdt_pkg;

   // request kinds
   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // result events
   localparam logic [2:0] EV_OPENED    = 3'd0;
   localparam logic [2:0] EV_REFUSED   = 3'd1;
   localparam logic [2:0] EV_HEADER    = 3'd2;
   localparam logic [2:0] EV_DATA      = 3'd3;
   localparam logic [2:0] EV_ERROR     = 3'd4;
   localparam logic [2:0] EV_ENDED     = 3'd5;
   localparam logic [2:0] EV_ERR_CLOSE = 3'd6;
   localparam logic [2:0] EV_MALFORMED = 3'd7;

   // most results reported for one fail-all
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic take_req;
      logic emit_second;
      logic open_step;
      logic open_commit;
      logic fail_step;
   } cmd_type;

   typedef struct packed {
      logic can_load;
      logic byte_two;
      logic no_free;
      logic idx_last;
      logic fail_need;
   } status_type;

endpackage

// ===== rtl/chdt_ctrl.sv =====
module chdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   output logic                 req_stall,
   input  chdt_pkg::status_type sts,
   output chdt_pkg::cmd_type    cmd
);
   import chdt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SECOND    = 5'b00010,
      ST_OPEN_SCAN = 5'b00100,
      ST_OPEN_DONE = 5'b01000,
      ST_FAIL_SCAN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // sequence commands per state
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !sts.can_load;
            if (req_valid && sts.can_load) begin
               cmd.take_req = 1'b1;
               priority if (req_kind == KIND_OPEN && !sts.no_free) begin
                  state_in = ST_OPEN_SCAN;
               end else if (req_kind == KIND_FAIL) begin
                  state_in = ST_FAIL_SCAN;
               end else if (req_kind == KIND_BYTE && sts.byte_two) begin
                  state_in = ST_SECOND;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SECOND: begin
            if (sts.can_load) begin
               cmd.emit_second = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_OPEN_SCAN: begin
            cmd.open_step = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_OPEN_DONE;
            end
         end
         ST_OPEN_DONE: begin
            if (sts.can_load) begin
               cmd.open_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_FAIL_SCAN: begin
            if (!sts.fail_need || sts.can_load) begin
               cmd.fail_step = 1'b1;
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/chdt_datapath.sv =====
module chdt_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_first_byte,
   input  logic                 req_last_byte,
   input  logic                 req_packet_error,
   input  logic                 rsp_stall,
   input  chdt_pkg::cmd_type    cmd,
   output chdt_pkg::status_type sts,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_event_res,
   output logic [15:0]          rsp_stream_id,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_segment_end,
   output logic                 rsp_last_result
);
   import chdt_pkg::*;

   localparam int IDXW = $clog2(NUM_SLOTS);

   typedef enum logic [7:0] {
      POS_IDLE     = 8'b00000001,
      POS_ID_LO    = 8'b00000010,
      POS_LEN_HI   = 8'b00000100,
      POS_LEN_LO   = 8'b00001000,
      POS_SEG      = 8'b00010000,
      POS_BODY     = 8'b00100000,
      POS_ERR_BODY = 8'b01000000,
      POS_TAIL     = 8'b10000000
   } pos_type;

   // channel table
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] phase_ff;
   logic [15:0]          id_ff [NUM_SLOTS];
   logic [15:0]          nfid_ff, nfid_in;

   // packet parser
   pos_type     pos_ff, pos_in;
   logic [7:0]  id_hi_ff, id_hi_in;
   logic [IDXW-1:0] cur_ff, cur_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] rem_ff, rem_in;
   logic        szl_ff, szl_in;

   // open and fail-all sweeps
   logic [IDXW-1:0]  free_ff, free_in;
   logic [16:0]      cand_ff, cand_in;
   logic [IDXW-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // result register and held second result
   logic        out_v_ff, out_v_in;
   logic [2:0]  out_ev_ff, out_ev_in;
   logic [15:0] out_id_ff, out_id_in;
   logic [7:0]  out_db_ff, out_db_in;
   logic        out_se_ff, out_se_in;
   logic        out_last_ff, out_last_in;
   logic [2:0]  sec_ev_ff;
   logic [15:0] sec_id_ff;

   // lookups
   logic            any_free, hit_any, can_load;
   logic [IDXW-1:0] free_idx, hit_idx;
   logic [15:0]     id_lk, cs_id, sweep_id;
   logic            fail_need, any_above, fail_last;
   logic [16:0]     sweep_inc;

   // byte path results
   logic            r0_v, r0_se, r1_v;
   logic [2:0]      r0_ev, r1_ev;
   logic [7:0]      r0_db;
   logic [15:0]     res_id, rem_dec, len_full;
   logic            b_close, b_set_phase;
   logic [IDXW-1:0] b_close_idx;
   logic [15:0]     b_close_id;
   logic            is_byte;

   assign can_load  = !out_v_ff || !rsp_stall;
   assign id_lk     = {id_hi_ff, req_byte_value};
   assign cs_id     = id_ff[cur_ff];
   assign sweep_id  = id_ff[idx_ff];
   assign sweep_inc = {1'b0, sweep_id} + 17'd1;
   assign len_full  = {len_hi_ff, req_byte_value};
   assign rem_dec   = rem_ff - 16'd1;
   assign is_byte   = cmd.take_req && (req_kind == KIND_BYTE);

   // find lowest free slot and lowest matching slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      hit_any  = 1'b0;
      hit_idx  = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            any_free = 1'b1;
            free_idx = IDXW'(s);
         end
         if (valid_ff[s] && id_ff[s] == id_lk) begin
            hit_any = 1'b1;
            hit_idx = IDXW'(s);
         end
      end
   end

   // fail-all sweep status
   assign fail_need = valid_ff[idx_ff] && (cnt_ff < CNT_W'(MAX_RESULTS));
   assign any_above = ((valid_ff >> idx_ff) >> 1) != '0;
   assign fail_last = (cnt_ff == CNT_W'(MAX_RESULTS - 1)) || !any_above;

   assign sts.can_load  = can_load;
   assign sts.byte_two  = r1_v;
   assign sts.no_free   = !any_free;
   assign sts.idx_last  = (idx_ff == IDXW'(NUM_SLOTS - 1));
   assign sts.fail_need = fail_need;

   // parse one packet byte
   always_comb begin
      r0_v        = 1'b0;
      r0_ev       = EV_OPENED;
      r0_db       = 8'd0;
      r0_se       = 1'b0;
      r1_v        = 1'b0;
      r1_ev       = EV_MALFORMED;
      res_id      = cs_id;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      len_hi_in   = len_hi_ff;
      rem_in      = rem_ff;
      szl_in      = szl_ff;
      id_hi_in    = id_hi_ff;
      b_close     = 1'b0;
      b_close_idx = cur_ff;
      b_close_id  = cs_id;
      b_set_phase = 1'b0;
      if (req_first_byte) begin
         id_hi_in = req_byte_value;
         pos_in   = req_last_byte ? POS_IDLE : POS_ID_LO;
      end else begin
         unique case (pos_ff)
            POS_IDLE: begin
            end
            POS_ID_LO: begin
               if (!hit_any) begin
                  pos_in = POS_IDLE;
               end else begin
                  cur_in      = hit_idx;
                  szl_in      = 1'b0;
                  res_id      = id_lk;
                  b_close_idx = hit_idx;
                  b_close_id  = id_lk;
                  priority if (req_packet_error) begin
                     pos_in = POS_ERR_BODY;
                     if (req_last_byte) begin
                        r0_v    = 1'b1;
                        r0_ev   = EV_ERR_CLOSE;
                        b_close = 1'b1;
                        pos_in  = POS_IDLE;
                     end
                  end else if (phase_ff[hit_idx]) begin
                     pos_in = POS_BODY;
                     if (req_last_byte) begin
                        r0_v    = 1'b1;
                        r0_ev   = EV_ENDED;
                        b_close = 1'b1;
                        pos_in  = POS_IDLE;
                     end
                  end else begin
                     pos_in = POS_LEN_HI;
                     if (req_last_byte) begin
                        r0_v   = 1'b1;
                        r0_ev  = EV_MALFORMED;
                        pos_in = POS_IDLE;
                     end
                  end
               end
            end
            POS_LEN_HI: begin
               len_hi_in = req_byte_value;
               pos_in    = POS_LEN_LO;
               if (req_last_byte) begin
                  r0_v   = 1'b1;
                  r0_ev  = EV_MALFORMED;
                  pos_in = POS_IDLE;
               end
            end
            POS_LEN_LO: begin
               if (len_full == 16'd0) begin
                  szl_in = 1'b1;
                  pos_in = POS_TAIL;
                  if (req_last_byte) begin
                     b_set_phase = 1'b1;
                     pos_in      = POS_IDLE;
                  end
               end else begin
                  rem_in = len_full;
                  pos_in = POS_SEG;
                  if (req_last_byte) begin
                     r0_v   = 1'b1;
                     r0_ev  = EV_MALFORMED;
                     pos_in = POS_IDLE;
                  end
               end
            end
            POS_SEG: begin
               rem_in = rem_dec;
               r0_v   = 1'b1;
               r0_ev  = EV_HEADER;
               r0_db  = req_byte_value;
               r0_se  = (rem_dec == 16'd0);
               if (rem_dec == 16'd0) begin
                  pos_in = req_last_byte ? POS_IDLE : POS_LEN_HI;
               end else if (req_last_byte) begin
                  r1_v   = 1'b1;
                  r1_ev  = EV_MALFORMED;
                  pos_in = POS_IDLE;
               end
            end
            POS_TAIL: begin
               szl_in = 1'b0;
               if (req_last_byte) begin
                  r0_v   = 1'b1;
                  r0_ev  = EV_MALFORMED;
                  pos_in = POS_IDLE;
               end
            end
            POS_BODY: begin
               r0_v  = 1'b1;
               r0_ev = EV_DATA;
               r0_db = req_byte_value;
               if (req_last_byte) begin
                  pos_in = POS_IDLE;
               end
            end
            POS_ERR_BODY: begin
               r0_v  = 1'b1;
               r0_ev = EV_ERROR;
               r0_db = req_byte_value;
               if (req_last_byte) begin
                  r1_v    = 1'b1;
                  r1_ev   = EV_ERR_CLOSE;
                  b_close = 1'b1;
                  pos_in  = POS_IDLE;
               end
            end
            default: begin
               pos_in = POS_IDLE;
            end
         endcase
      end
   end

   // next table and sweep state
   always_comb begin
      valid_in = valid_ff;
      nfid_in  = nfid_ff;
      free_in  = free_ff;
      cand_in  = cand_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      if (cmd.take_req) begin
         free_in = free_idx;
         cand_in = {1'b0, nfid_ff} + 17'd1;
         idx_in  = '0;
         cnt_in  = '0;
      end
      if (is_byte && b_close) begin
         valid_in[b_close_idx] = 1'b0;
         if (b_close_id < nfid_ff) begin
            nfid_in = b_close_id;
         end
      end
      if (cmd.open_step) begin
         if (valid_ff[idx_ff] && sweep_inc > cand_ff) begin
            cand_in = sweep_inc;
         end
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.open_commit) begin
         valid_in[free_ff] = 1'b1;
         nfid_in           = cand_ff[15:0];
      end
      if (cmd.fail_step) begin
         if (valid_ff[idx_ff]) begin
            valid_in[idx_ff] = 1'b0;
            if (sweep_id < nfid_ff) begin
               nfid_in = sweep_id;
            end
         end
         if (fail_need) begin
            cnt_in = cnt_ff + 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   // load the result register
   always_comb begin
      out_v_in    = out_v_ff && rsp_stall;
      out_ev_in   = out_ev_ff;
      out_id_in   = out_id_ff;
      out_db_in   = out_db_ff;
      out_se_in   = out_se_ff;
      out_last_in = out_last_ff;
      priority if (cmd.take_req && req_kind == KIND_OPEN && !any_free) begin
         out_v_in    = 1'b1;
         out_ev_in   = EV_REFUSED;
         out_id_in   = nfid_ff;
         out_db_in   = 8'd0;
         out_se_in   = 1'b0;
         out_last_in = 1'b1;
      end else if (is_byte && r0_v) begin
         out_v_in    = 1'b1;
         out_ev_in   = r0_ev;
         out_id_in   = res_id;
         out_db_in   = r0_db;
         out_se_in   = r0_se;
         out_last_in = !r1_v;
      end else if (cmd.emit_second) begin
         out_v_in    = 1'b1;
         out_ev_in   = sec_ev_ff;
         out_id_in   = sec_id_ff;
         out_db_in   = 8'd0;
         out_se_in   = 1'b0;
         out_last_in = 1'b1;
      end else if (cmd.open_commit) begin
         out_v_in    = 1'b1;
         out_ev_in   = EV_OPENED;
         out_id_in   = nfid_ff;
         out_db_in   = 8'd0;
         out_se_in   = 1'b0;
         out_last_in = 1'b1;
      end else if (cmd.fail_step && fail_need) begin
         out_v_in    = 1'b1;
         out_ev_in   = EV_ERR_CLOSE;
         out_id_in   = sweep_id;
         out_db_in   = 8'd0;
         out_se_in   = 1'b0;
         out_last_in = fail_last;
      end else begin
         out_v_in    = out_v_ff && rsp_stall;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         nfid_ff  <= '0;
         pos_ff   <= POS_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         nfid_ff  <= nfid_in;
         out_v_ff <= out_v_in;
         if (is_byte) begin
            pos_ff <= pos_in;
         end else if (cmd.take_req && req_kind == KIND_FAIL) begin
            pos_ff <= POS_IDLE;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      cand_ff     <= cand_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      out_ev_ff   <= out_ev_in;
      out_id_ff   <= out_id_in;
      out_db_ff   <= out_db_in;
      out_se_ff   <= out_se_in;
      out_last_ff <= out_last_in;
      if (is_byte) begin
         id_hi_ff  <= id_hi_in;
         cur_ff    <= cur_in;
         len_hi_ff <= len_hi_in;
         rem_ff    <= rem_in;
         szl_ff    <= szl_in;
         sec_ev_ff <= r1_ev;
         sec_id_ff <= res_id;
      end
   end

   // write table ids and phases
   always_ff @(posedge clock) begin
      if (cmd.open_commit) begin
         id_ff[free_ff]    <= nfid_ff;
         phase_ff[free_ff] <= 1'b0;
      end else if (is_byte && b_set_phase) begin
         phase_ff[cur_ff] <= 1'b1;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_event_res   = out_ev_ff;
   assign rsp_stream_id   = out_id_ff;
   assign rsp_data_byte   = out_db_ff;
   assign rsp_segment_end = out_se_ff;
   assign rsp_last_result = out_last_ff;

endmodule

// ===== rtl/channel_demux_table_top.sv =====
// Channel   Prefix  Direction  Fields
// request   req_    in         kind, byte_value, first_byte, last_byte, packet_error
// result    rsp_    out        event_res, stream_id, data_byte, segment_end, last_result
//
// A packet byte that yields two results holds the next request until the
// second result is loaded. An open sweeps the table for the highest live id
// and then commits; a refused open needs no sweep. Fail-all steps through
// every slot and waits on a full result register only for a slot it reports.
// Reset is synchronous and clears the table at once. The request side stalls
// while the result register is full and rsp_stall is high, and outside idle.
module channel_demux_table_top #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        req_packet_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_stream_id,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_segment_end,
   output logic        rsp_last_result
);
   import chdt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   chdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   chdt_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_byte_value   (req_byte_value),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_packet_error (req_packet_error),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_event_res    (rsp_event_res),
      .rsp_stream_id    (rsp_stream_id),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_segment_end  (rsp_segment_end),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== rtl/chdt_port_check.sv =====
`include "channel_demux_table_top_macros.svh"

module chdt_port_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_segment_end
);
   import chdt_pkg::*;

   logic no_byte;

   // events that carry no byte
   assign no_byte = rsp_event_res != EV_HEADER && rsp_event_res != EV_DATA &&
                    rsp_event_res != EV_ERROR;

   // hold a stalled result
   `CHDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // zero the byte on events that carry none
   `CHDT_ASSERT_SAME(a_byte_zero, clock, reset, rsp_valid && no_byte, rsp_data_byte == 8'd0)

   // mark segment ends only on header bytes
   `CHDT_ASSERT_SAME(a_seg_end, clock, reset, rsp_valid && rsp_segment_end, rsp_event_res == EV_HEADER)

   // come out of reset with no result pending
   `CHDT_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind channel_demux_table_top chdt_port_check u_port_check (.*);

// ===== tb/sv/channel_demux_table_top_test.sv =====
module channel_demux_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import chdt_pkg::*;

   localparam int SLOTS    = 16;
   localparam int IDLE_MAX = 20000;
   localparam int HOLD_LEN = 300;
   localparam int N_ITEMS  = 160;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   typedef struct {
      logic [2:0]  ev;
      logic [15:0] id;
      logic [7:0]  data;
      logic        seg_end;
      logic        last;
   } event_type;

   typedef enum logic [2:0] {
      P_IDLE, P_ID_LO, P_LEN_HI, P_LEN_LO, P_SEG, P_BODY, P_ERR_BODY, P_TAIL
   } parse_type;

   // Channel table model and expected event queue
   class demux_scoreboard;
      bit          live [SLOTS];
      logic [15:0] chan [SLOTS];
      bit          data_phase [SLOTS];
      logic [15:0] free_id;
      parse_type   pos;
      logic [7:0]  id_hi, len_hi;
      int          cur;
      logic [15:0] seg_left;
      bit          zero_len;
      event_type   pending [$];
      int          errors;
      event_type   batch [$];

      function void clear();
         foreach (live[i]) begin
            live[i] = 0;
            chan[i] = '0;
            data_phase[i] = 0;
         end
         free_id = '0;
         pos = P_IDLE;
         id_hi = '0;
         len_hi = '0;
         cur = 0;
         seg_left = '0;
         zero_len = 0;
         pending.delete();
         errors = 0;
      endfunction

      function void emit(logic [2:0] ev, logic [15:0] id, logic [7:0] d, logic se);
         event_type e;
         if (batch.size() >= MAX_RESULTS) return;
         e.ev = ev;
         e.id = id;
         e.data = d;
         e.seg_end = se;
         e.last = 0;
         batch.push_back(e);
      endfunction

      function void drop_slot(int s);
         live[s] = 0;
         if (chan[s] < free_id) free_id = chan[s];
      endfunction

      // Predict the events one request causes
      function void note_request(logic [1:0] kind, logic [7:0] b, logic first,
                                 logic last_in, logic err);
         int          fs;
         logic [16:0] cand;
         logic [15:0] lkid, len;
         bit          last;
         last = last_in;
         batch.delete();
         if (kind == KIND_OPEN) begin
            fs = -1;
            for (int s = 0; s < SLOTS; s++)
               if (!live[s] && fs < 0) fs = s;
            if (fs < 0) begin
               emit(EV_REFUSED, free_id, 8'd0, 1'b0);
            end else begin
               cand = {1'b0, free_id} + 17'd1;
               for (int s = 0; s < SLOTS; s++)
                  if (live[s] && {1'b0, chan[s]} + 17'd1 > cand)
                     cand = {1'b0, chan[s]} + 17'd1;
               live[fs] = 1;
               chan[fs] = free_id;
               data_phase[fs] = 0;
               emit(EV_OPENED, free_id, 8'd0, 1'b0);
               free_id = cand[15:0];
            end
         end else if (kind == KIND_FAIL) begin
            pos = P_IDLE;
            for (int s = 0; s < SLOTS; s++)
               if (live[s]) begin
                  emit(EV_ERR_CLOSE, chan[s], 8'd0, 1'b0);
                  drop_slot(s);
               end
         end else if (kind == KIND_BYTE) begin
            if (first) begin
               pos = last ? P_IDLE : P_ID_LO;
               id_hi = b;
            end else begin
               case (pos)
                  P_ID_LO: begin
                     lkid = {id_hi, b};
                     fs = -1;
                     for (int s = 0; s < SLOTS; s++)
                        if (live[s] && chan[s] == lkid && fs < 0) fs = s;
                     if (fs < 0) begin
                        pos = P_IDLE;
                     end else begin
                        cur = fs;
                        zero_len = 0;
                        if (err) begin
                           pos = P_ERR_BODY;
                           if (last) begin
                              emit(EV_ERR_CLOSE, chan[cur], 8'd0, 1'b0);
                              drop_slot(cur);
                              pos = P_IDLE;
                           end
                        end else if (data_phase[cur]) begin
                           pos = P_BODY;
                           if (last) begin
                              emit(EV_ENDED, chan[cur], 8'd0, 1'b0);
                              drop_slot(cur);
                              pos = P_IDLE;
                           end
                        end else begin
                           pos = P_LEN_HI;
                           if (last) begin
                              emit(EV_MALFORMED, chan[cur], 8'd0, 1'b0);
                              pos = P_IDLE;
                           end
                        end
                     end
                     last = 0;
                  end
                  P_LEN_HI: begin
                     len_hi = b;
                     pos = P_LEN_LO;
                  end
                  P_LEN_LO: begin
                     len = {len_hi, b};
                     if (len == 0) begin
                        zero_len = 1;
                        pos = P_TAIL;
                     end else begin
                        seg_left = len;
                        pos = P_SEG;
                     end
                  end
                  P_SEG: begin
                     seg_left = seg_left - 16'd1;
                     emit(EV_HEADER, chan[cur], b, seg_left == 0);
                     if (seg_left == 0) pos = P_LEN_HI;
                  end
                  P_TAIL: zero_len = 0;
                  P_BODY: emit(EV_DATA, chan[cur], b, 1'b0);
                  P_ERR_BODY: emit(EV_ERROR, chan[cur], b, 1'b0);
                  default: last = 0;
               endcase
               if (last && pos != P_IDLE) begin
                  case (pos)
                     P_LEN_LO, P_SEG: emit(EV_MALFORMED, chan[cur], 8'd0, 1'b0);
                     P_TAIL: begin
                        if (zero_len) data_phase[cur] = 1;
                        else emit(EV_MALFORMED, chan[cur], 8'd0, 1'b0);
                     end
                     P_ERR_BODY: begin
                        emit(EV_ERR_CLOSE, chan[cur], 8'd0, 1'b0);
                        drop_slot(cur);
                     end
                     default: ;
                  endcase
                  pos = P_IDLE;
               end
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1;
         foreach (batch[i]) pending.push_back(batch[i]);
      endfunction

      // Compare one result with the oldest expected event
      function void check_result(logic [2:0] ev, logic [15:0] id, logic [7:0] d,
                                 logic se, logic lr);
         event_type e;
         if (pending.size() == 0) begin
            $error("unexpected result ev=%0d id=%0h", ev, id);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (ev !== e.ev) begin
            $error("event_res expected %0d got %0d", e.ev, ev);
            errors++;
         end
         if (id !== e.id) begin
            $error("stream_id expected %0h got %0h", e.id, id);
            errors++;
         end
         if (d !== e.data) begin
            $error("data_byte expected %0h got %0h", e.data, d);
            errors++;
         end
         if (se !== e.seg_end) begin
            $error("segment_end expected %0b got %0b", e.seg_end, se);
            errors++;
         end
         if (lr !== e.last) begin
            $error("last_result expected %0b got %0b", e.last, lr);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_OPEN;
   logic [7:0]  req_byte_value = '0;
   logic        req_first_byte = 0;
   logic        req_last_byte = 0;
   logic        req_packet_error = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_stream_id;
   logic [7:0]  rsp_data_byte;
   logic        rsp_segment_end;
   logic        rsp_last_result;

   demux_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  hold_off = 0;
   int  hold_cnt = 0;
   int  burst_left = 0;
   int  n_sent = 0;

   channel_demux_table_top #(.NUM_SLOTS(SLOTS)) dut (.*);

   always #2 clock = ~clock;

   // Note accepted requests and check results at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_kind, req_byte_value, req_first_byte,
                            req_last_byte, req_packet_error);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_event_res, rsp_stream_id, rsp_data_byte,
                            rsp_segment_end, rsp_last_result);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Stall the result side on its own pattern, with one long hold-off
   always @(negedge clock) begin
      if (hold_off && hold_cnt < HOLD_LEN) begin
         hold_cnt <= hold_cnt + 1;
         rsp_stall <= 1;
      end else if (burst_left > 0) begin
         burst_left <= burst_left - 1;
         rsp_stall <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
         burst_left <= $urandom_range(10, 60);
         rsp_stall <= 0;
      end else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Offer one request and hold it until accepted
   task automatic send(logic [1:0] kind, logic [7:0] b, logic first, logic last,
                       logic err);
      req_valid <= 1;
      req_kind <= kind;
      req_byte_value <= b;
      req_first_byte <= first;
      req_last_byte <= last;
      req_packet_error <= err;
      do @(posedge clock); while (req_stall);
      n_sent++;
      @(negedge clock);
      if ($urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // Send a whole packet: id, then payload bytes
   task automatic send_packet(logic [15:0] id, logic [7:0] body [$], logic err);
      if (body.size() == 0) begin
         send(KIND_BYTE, id[15:8], 1, 0, err);
         send(KIND_BYTE, id[7:0], 0, 1, err);
      end else begin
         send(KIND_BYTE, id[15:8], 1, 0, err);
         send(KIND_BYTE, id[7:0], 0, 0, err);
         foreach (body[i]) send(KIND_BYTE, body[i], 0, i == body.size() - 1, err);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SLOTS + 8) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_id();
      if (sb.free_id > 0 && $urandom_range(0, 7) != 0)
         return 16'($urandom_range(0, sb.free_id));
      return 16'($urandom());
   endfunction

   // Random header payload: segments, possibly a zero length, maybe broken
   function automatic void header_body(ref logic [7:0] body [$]);
      int nseg;
      int len;
      nseg = $urandom_range(0, 2);
      for (int k = 0; k < nseg; k++) begin
         len = $urandom_range(1, 4);
         body.push_back(8'h00);
         body.push_back(8'(len));
         for (int j = 0; j < len; j++) body.push_back(8'($urandom()));
      end
      if ($urandom_range(0, 2) != 0) begin
         body.push_back(8'h00);
         body.push_back(8'h00);
      end
      case ($urandom_range(0, 5))
         0: body.push_back(8'($urandom()));
         1: if (body.size() > 0) void'(body.pop_back());
         default: ;
      endcase
   endfunction

   initial begin
      logic [7:0] body [$];
      logic [15:0] id;
      sb.clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: opens, header segments, data, errors, malformed, fail-all
      send(KIND_OPEN, 0, 0, 0, 0);
      send(KIND_OPEN, 8'hFF, 1, 1, 1);
      body = '{8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00};
      send_packet(16'h0000, body, 0);
      body = '{8'hAB, 8'h55};
      send_packet(16'h0000, body, 0);
      body = '{};
      send_packet(16'h0000, body, 0);
      body = '{8'h00};
      send_packet(16'h0001, body, 0);
      body = '{};
      send_packet(16'h0001, body, 0);
      body = '{8'h12};
      send_packet(16'h0001, body, 1);
      send(KIND_BYTE, 8'hFF, 1, 1, 0);
      send(KIND_BYTE, 8'h77, 0, 1, 0);
      body = '{8'h00, 8'h00, 8'h99};
      send_packet(16'hFFFF, body, 0);
      send(KIND_OPEN, 0, 0, 0, 0);
      send(KIND_BYTE, 8'h00, 1, 0, 0);
      send(KIND_FAIL, 0, 0, 0, 0);
      send(KIND_BYTE, 8'h00, 0, 1, 0);
      send(KIND_IGNORED, 8'hFF, 1, 1, 1);

      // Pause until everything has drained
      wait_drain();

      // Fill the table past capacity while the result side holds off
      hold_off = 1;
      repeat (SLOTS + 2) send(KIND_OPEN, 8'($urandom()), 0, 0, 0);
      hold_off = 0;
      wait_drain();
      body = '{8'h00, 8'h00};
      send_packet(16'h0010, body, 0);

      // Random well-formed traffic with some noise
      while (n_sent < N_ITEMS) begin
         id = pick_id();
         body.delete();
         case ($urandom_range(0, 19))
            0, 1, 2: send(KIND_OPEN, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                          1'($urandom()));
            3: if ($urandom_range(0, 3) == 0) send(KIND_FAIL, 8'($urandom()), 0, 0, 0);
            4: send(2'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()),
                    1'($urandom()), 1'($urandom()));
            5: send_packet(id, body, 1'($urandom_range(0, 1)));
            6, 7: begin
               repeat ($urandom_range(1, 5)) body.push_back(8'($urandom()));
               send_packet(id, body, 1);
            end
            8, 9, 10: begin
               repeat ($urandom_range(1, 6)) body.push_back(8'($urandom()));
               send_packet(id, body, 0);
            end
            default: begin
               header_body(body);
               send_packet(id, body, 0);
            end
         endcase
      end

      wait_drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/chdt_pkg.sv
rtl/chdt_ctrl.sv
rtl/chdt_datapath.sv
rtl/channel_demux_table_top.sv
rtl/chdt_port_check.sv
tb/sv/channel_demux_table_top_test.sv
